>>> hdl/nhist_pkg.sv
// Shared types and constants of the normalized histogram block.
`default_nettype none
package nhist_pkg;

	localparam int DATA_W      = 32;
	localparam int BKT_W       = 6;
	localparam int SPAN_W      = 33;
	localparam int PROD_W      = 38;
	localparam int SHARE_W     = 10;
	localparam int QUEUE_DEPTH = 2;
	localparam int REG_IDX_W   = 2;
	localparam int SHARE_SCALE2 = 2000;

	localparam int DEF_MAX_BUCKETS = 32;
	localparam int DEF_COUNT_WIDTH = 20;

	localparam logic [DATA_W-1:0] RANGE_LOW_RST    = 32'd0;
	localparam logic [DATA_W-1:0] RANGE_HIGH_RST   = 32'd65535;
	localparam logic [BKT_W-1:0]  BUCKET_COUNT_RST = 6'd32;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_RANGE_LOW    = 2'd0,
		REG_RANGE_HIGH   = 2'd1,
		REG_BUCKET_COUNT = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_MIN   = 2'd0,
		KIND_MAX   = 2'd1,
		KIND_SHARE = 2'd2
	} kind_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] sample;
		logic                     final_sample;
	} in_t;

	typedef struct packed {
		kind_t                    kind;
		logic [BKT_W-1:0]         bucket_index;
		logic signed [DATA_W-1:0] value;
		logic                     last;
	} out_t;

	typedef struct packed {
		logic [PROD_W-1:0] prod;
		logic [SPAN_W-1:0] span;
		logic              hit;
		logic              fin;
	} qent_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_DIV,
		BK_RD,
		BK_UPD,
		BK_MIN,
		BK_MAX,
		BK_SRD,
		BK_SLD,
		BK_SDIV,
		BK_SOUT
	} back_st_t;

endpackage
`default_nettype wire

>>> hdl/nhist_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module nhist_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 32
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic                                      re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> hdl/nhist_div.sv
// Restoring divider that retires one quotient bit per cycle.
`default_nettype none
module nhist_div
	import nhist_pkg::*;
#(
	parameter int NUM_W = 38,
	parameter int DEN_W = 33,
	parameter int QUO_W = 10
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             go,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  done,
	output logic      [QUO_W-1:0] quo
);

	localparam int SH_W = DEN_W + QUO_W - 1;
	localparam int W    = (NUM_W > SH_W) ? NUM_W : SH_W;
	localparam int ST_W = $clog2(QUO_W + 1);

	logic [W-1:0]     rem_q;
	logic [W-1:0]     dsh_q;
	logic [QUO_W-1:0] quo_q;
	logic [ST_W-1:0]  step_q;
	logic             run_q;
	logic             done_q;
	logic             ge;

	assign ge   = (rem_q >= dsh_q);
	assign done = done_q;
	assign quo  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q  <= 1'b1;
				step_q <= ST_W'(QUO_W);
			end else if (run_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == ST_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= W'(num);
			dsh_q <= W'(den) << (QUO_W - 1);
			quo_q <= '0;
		end else if (run_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[QUO_W-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

endmodule
`default_nettype wire

>>> hdl/nhist_fifo.sv
// Short queue of classified samples between the front and back parts.
`default_nettype none
module nhist_fifo
	import nhist_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire qent_t din,
	input  wire logic  pop,
	output qent_t      dout,
	output logic       empty,
	output logic       full
);

	localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNW = $clog2(QUEUE_DEPTH + 1);

	qent_t          ent_q [QUEUE_DEPTH];
	logic [QAW-1:0] wptr_q;
	logic [QAW-1:0] rptr_q;
	logic [CNW-1:0] cnt_q;

	assign dout  = ent_q[rptr_q];
	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CNW'(QUEUE_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= din;
		end
	end

endmodule
`default_nettype wire

>>> hdl/nhist_front.sv
// Front part: takes samples, tracks minimum and maximum, classifies buckets.
`default_nettype none
module nhist_front
	import nhist_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire in_t               item,
	input  wire logic [DATA_W-1:0] range_low,
	input  wire logic [DATA_W-1:0] range_high,
	input  wire logic [BKT_W-1:0]  k,
	input  wire logic              full,
	input  wire logic              run_done,
	output logic                   busy,
	output logic                   push,
	output qent_t                  entry,
	output logic signed [DATA_W-1:0] obs_min,
	output logic signed [DATA_W-1:0] obs_max
);

	logic                     vld_s1;
	logic                     fin_s1;
	logic [DATA_W:0]          off_s1;
	logic [DATA_W+1:0]        span_s1;
	logic signed [DATA_W-1:0] min_q;
	logic signed [DATA_W-1:0] max_q;
	logic                     run_open_q;
	logic                     fin_pend_q;
	logic                     accept;
	logic signed [DATA_W-1:0] seed_min;
	logic signed [DATA_W-1:0] seed_max;

	assign busy     = vld_s1 | full | fin_pend_q;
	assign accept   = start & ~busy;
	assign seed_min = run_open_q ? min_q : $signed(range_high);
	assign seed_max = run_open_q ? max_q : $signed(range_low);
	assign obs_min  = min_q;
	assign obs_max  = max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			run_open_q <= 1'b0;
			fin_pend_q <= 1'b0;
		end else begin
			vld_s1 <= accept;
			if (accept) begin
				run_open_q <= 1'b1;
				fin_pend_q <= item.final_sample;
			end else if (run_done) begin
				run_open_q <= 1'b0;
				fin_pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fin_s1  <= item.final_sample;
			off_s1  <= {item.sample[DATA_W-1], item.sample} - {range_low[DATA_W-1], range_low};
			span_s1 <= {{2{range_high[DATA_W-1]}}, range_high}
				- {{2{range_low[DATA_W-1]}}, range_low} + (DATA_W+2)'(1);
			min_q   <= (item.sample < seed_min) ? item.sample : seed_min;
			max_q   <= (item.sample > seed_max) ? item.sample : seed_max;
		end
	end

	// A sample counts only if the range is not empty and it lies inside it.
	always_comb begin
		push       = vld_s1;
		entry.fin  = fin_s1;
		entry.span = span_s1[SPAN_W-1:0];
		entry.hit  = !span_s1[DATA_W+1] && (span_s1 != '0) && !off_s1[DATA_W]
			&& ({1'b0, off_s1} < span_s1);
		entry.prod = PROD_W'(off_s1[DATA_W-1:0]) * PROD_W'(k);
	end

endmodule
`default_nettype wire

>>> hdl/nhist_back.sv
// Back part: bucket index division, count update and the end-of-run report.
`default_nettype none
module nhist_back
	import nhist_pkg::*;
#(
	parameter int MAX_BUCKETS = DEF_MAX_BUCKETS,
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic [BKT_W-1:0]         k,
	input  wire logic                     empty,
	input  wire qent_t                    head,
	input  wire logic signed [DATA_W-1:0] obs_min,
	input  wire logic signed [DATA_W-1:0] obs_max,
	output logic                          pop,
	output logic                          run_done,
	output logic                          strobe,
	output out_t                          result
);

	localparam int AW     = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
	localparam int SNUM_W = COUNT_WIDTH + 12;
	localparam int NUM_W  = (PROD_W > SNUM_W) ? PROD_W : SNUM_W;
	localparam int DEN_W  = (SPAN_W > COUNT_WIDTH + 1) ? SPAN_W : COUNT_WIDTH + 1;

	back_st_t               st_q;
	back_st_t               st_d;
	logic                   fin_q;
	logic                   vrd_q;
	logic [AW-1:0]          addr_q;
	logic [BKT_W-1:0]       i_q;
	logic [COUNT_WIDTH-1:0] peak_q;
	logic [MAX_BUCKETS-1:0] vbit_q;
	logic                   strobe_q;
	out_t                   result_q;

	logic                   div_go;
	logic [NUM_W-1:0]       div_num;
	logic [DEN_W-1:0]       div_den;
	logic                   div_done;
	logic [SHARE_W-1:0]     div_quo;
	logic                   re;
	logic                   we;
	logic [AW-1:0]          raddr;
	logic [COUNT_WIDTH-1:0] rdata;
	logic [COUNT_WIDTH-1:0] cur;
	logic [COUNT_WIDTH-1:0] nxt;
	logic                   emit;
	out_t                   res_d;
	logic                   last_bkt;

	nhist_div #(
		.NUM_W(NUM_W),
		.DEN_W(DEN_W),
		.QUO_W(SHARE_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (div_go),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_quo)
	);

	nhist_ram #(
		.WIDTH(COUNT_WIDTH),
		.DEPTH(MAX_BUCKETS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(addr_q),
		.wdata(nxt),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// A bucket not written since the last report reads as zero.
	assign cur      = vrd_q ? rdata : '0;
	assign nxt      = (cur == '1) ? cur : cur + 1'b1;
	assign last_bkt = (i_q == k - 1'b1);
	assign strobe   = strobe_q;
	assign result   = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d     = st_q;
		pop      = 1'b0;
		div_go   = 1'b0;
		div_num  = '0;
		div_den  = '0;
		re       = 1'b0;
		we       = 1'b0;
		raddr    = '0;
		emit     = 1'b0;
		run_done = 1'b0;
		res_d    = '0;
		case (st_q)
			BK_IDLE: begin
				if (!empty) begin
					pop = 1'b1;
					if (head.hit) begin
						div_go  = 1'b1;
						div_num = NUM_W'(head.prod);
						div_den = DEN_W'(head.span);
						st_d    = BK_DIV;
					end else if (head.fin) begin
						st_d = BK_MIN;
					end
				end
			end
			BK_DIV: begin
				if (div_done) begin
					st_d = BK_RD;
				end
			end
			BK_RD: begin
				re    = 1'b1;
				raddr = div_quo[AW-1:0];
				st_d  = BK_UPD;
			end
			BK_UPD: begin
				we   = 1'b1;
				st_d = fin_q ? BK_MIN : BK_IDLE;
			end
			BK_MIN: begin
				emit       = 1'b1;
				res_d.kind = KIND_MIN;
				res_d.value = obs_min;
				st_d       = BK_MAX;
			end
			BK_MAX: begin
				emit       = 1'b1;
				res_d.kind = KIND_MAX;
				res_d.value = obs_max;
				st_d       = BK_SRD;
			end
			BK_SRD: begin
				re    = 1'b1;
				raddr = i_q[AW-1:0];
				st_d  = BK_SLD;
			end
			BK_SLD: begin
				div_go  = 1'b1;
				div_num = NUM_W'(cur) * NUM_W'(SHARE_SCALE2) + NUM_W'(peak_q);
				div_den = DEN_W'({peak_q, 1'b0});
				st_d    = BK_SDIV;
			end
			BK_SDIV: begin
				if (div_done) begin
					st_d = BK_SOUT;
				end
			end
			BK_SOUT: begin
				emit               = 1'b1;
				res_d.kind         = KIND_SHARE;
				res_d.bucket_index = i_q;
				res_d.value        = (peak_q == '0) ? '0 : DATA_W'(div_quo);
				res_d.last         = last_bkt;
				if (last_bkt) begin
					run_done = 1'b1;
					st_d     = BK_IDLE;
				end else begin
					st_d = BK_SRD;
				end
			end
			default: begin
				st_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vbit_q   <= '0;
			peak_q   <= '0;
			strobe_q <= 1'b0;
			i_q      <= '0;
		end else begin
			strobe_q <= emit;
			if (run_done) begin
				vbit_q <= '0;
				peak_q <= '0;
			end else if (we) begin
				vbit_q[addr_q] <= 1'b1;
				if (nxt > peak_q) begin
					peak_q <= nxt;
				end
			end
			if (st_q == BK_MAX) begin
				i_q <= '0;
			end else if (st_q == BK_SOUT && !last_bkt) begin
				i_q <= i_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			fin_q <= head.fin;
		end
		if (re) begin
			vrd_q  <= vbit_q[raddr];
			addr_q <= raddr;
		end
		if (emit) begin
			result_q <= res_d;
		end
	end

endmodule
`default_nettype wire

>>> hdl/normalized_histogram_with_min_max.sv
// Top level of the equal-width histogram with running minimum and maximum.
//
// A sample word is taken at a clock edge where start is high and busy is low.
// The front part holds each sample in its s1 register and is busy meanwhile.
// For a sample that falls in a bucket the back part waits on the shared
// divider that retires one quotient bit per cycle; a dropped sample leaves
// the queue with no division. A two-entry queue lets the front keep taking
// samples while the back works, and busy rises when the queue fills.
// After a final sample the block stays busy and reports on result with a
// one-cycle strobe: the minimum, the maximum, then one share word per bucket
// in use, each share worked out through the same divider. The receiver
// must take each word in the cycle it is shown. The last word carries last.
// Configuration words on the cfg channel are to be given only while idle; the block does not enforce this.
// Reset loads the register defaults and empties the store at once: the
// bucket counts read as zero through valid bits, so there is no clearing pass.
`default_nettype none
module normalized_histogram_with_min_max
	import nhist_pkg::*;
#(
	parameter int MAX_BUCKETS = DEF_MAX_BUCKETS,
	parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire in_t                  item,
	output logic                      busy,
	output logic                      strobe,
	output out_t                      result,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [DATA_W-1:0]    cfg_data
);

	logic [DATA_W-1:0]        range_low_q;
	logic [DATA_W-1:0]        range_high_q;
	logic [BKT_W-1:0]         bucket_count_q;
	logic [BKT_W-1:0]         k_eff;
	logic                     q_full;
	logic                     q_empty;
	logic                     q_push;
	logic                     q_pop;
	qent_t                    q_in;
	qent_t                    q_head;
	logic                     run_done;
	logic signed [DATA_W-1:0] obs_min;
	logic signed [DATA_W-1:0] obs_max;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q    <= RANGE_LOW_RST;
			range_high_q   <= RANGE_HIGH_RST;
			bucket_count_q <= BUCKET_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RANGE_LOW:    range_low_q    <= cfg_data;
				REG_RANGE_HIGH:   range_high_q   <= cfg_data;
				REG_BUCKET_COUNT: bucket_count_q <= cfg_data[BKT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (bucket_count_q == '0) begin
			k_eff = BKT_W'(1);
		end else if (bucket_count_q > BKT_W'(MAX_BUCKETS)) begin
			k_eff = BKT_W'(MAX_BUCKETS);
		end else begin
			k_eff = bucket_count_q;
		end
	end

	nhist_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.range_low (range_low_q),
		.range_high(range_high_q),
		.k         (k_eff),
		.full      (q_full),
		.run_done  (run_done),
		.busy      (busy),
		.push      (q_push),
		.entry     (q_in),
		.obs_min   (obs_min),
		.obs_max   (obs_max)
	);

	nhist_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.din   (q_in),
		.pop   (q_pop),
		.dout  (q_head),
		.empty (q_empty),
		.full  (q_full)
	);

	nhist_back #(
		.MAX_BUCKETS(MAX_BUCKETS),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.k       (k_eff),
		.empty   (q_empty),
		.head    (q_head),
		.obs_min (obs_min),
		.obs_max (obs_max),
		.pop     (q_pop),
		.run_done(run_done),
		.strobe  (strobe),
		.result  (result)
	);

`ifndef SYNTHESIS
	a_final_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.final_sample |=> busy)
		else $error("final sample did not hold off further samples");

	a_report_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |-> busy)
		else $error("report word shown while the block was free");

	a_min_then_max: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.kind == KIND_MIN |=> strobe && result.kind == KIND_MAX)
		else $error("maximum word did not follow the minimum word");

	a_share_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.kind == KIND_SHARE |-> !result.value[DATA_W-1]
			&& result.value <= 32'sd1000)
		else $error("bucket share above one thousand");
`endif

endmodule
`default_nettype wire

>>> dv/normalized_histogram_with_min_max_test.sv
// Self-checking testbench for the normalized histogram block with running minimum and maximum.
module normalized_histogram_with_min_max_test;
	import nhist_pkg::*;

	localparam int  COUNT_W        = DEF_COUNT_WIDTH;
	localparam int  BUCKETS_MAX    = DEF_MAX_BUCKETS;
	localparam int  SETTLE_CYCLES  = 64;
	localparam int  RANDOM_ITEMS   = 88;
	localparam int  SHOWN_MISMATCH = 10;
	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [COUNT_W-1:0]   COUNT_SAT  = '1;

	typedef enum logic {
		ROW_CFG,
		ROW_SAMPLE
	} row_op_t;

	typedef struct packed {
		row_op_t                  op;
		logic [REG_IDX_W-1:0]     idx;
		logic [DATA_W-1:0]        data;
		logic                     fin;
		logic                     typed;
		logic signed [DATA_W-1:0] want_min;
		logic signed [DATA_W-1:0] want_max;
	} plan_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	in_t                  item;
	logic                 busy;
	logic                 strobe;
	out_t                 result;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0]    cfg_data;

	// Shadow copy of the registers and the histogram store.
	logic signed [DATA_W-1:0] cfg_low;
	logic signed [DATA_W-1:0] cfg_high;
	logic [BKT_W-1:0]         cfg_buckets;
	logic [COUNT_W-1:0]       bin_count [BUCKETS_MAX];
	logic [COUNT_W-1:0]       top_count;
	longint                   run_min;
	longint                   run_max;
	bit                       run_active;

	out_t      report_q [$];
	plan_row_t plan [$];
	int        fail_count;
	int        items_sent;
	bit        no_idle;

	normalized_histogram_with_min_max i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.busy      (busy),
		.strobe    (strobe),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#5000000;
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic flag(input string msg);
		fail_count++;
		if (fail_count <= SHOWN_MISMATCH) begin
			$display("%0t: %s", $time, msg);
		end
	endtask

	task automatic clear_histogram();
		for (int i = 0; i < BUCKETS_MAX; i++) begin
			bin_count[i] = '0;
		end
		top_count  = '0;
		run_min    = 0;
		run_max    = 0;
		run_active = 1'b0;
	endtask

	// Bins one accepted sample and, on the final one, queues the report words.
	task automatic histogram_step(input in_t w, input logic typed,
			input logic signed [DATA_W-1:0] want_min,
			input logic signed [DATA_W-1:0] want_max);
		longint x;
		longint span;
		longint off;
		longint bin;
		longint k;
		longint share;
		out_t   r;
		x = longint'($signed(w.sample));
		k = (cfg_buckets == 0) ? 1 : (cfg_buckets > BUCKETS_MAX) ? BUCKETS_MAX : cfg_buckets;
		span = longint'(cfg_high) - longint'(cfg_low) + 1;
		if (!run_active) begin
			run_min    = longint'(cfg_high);
			run_max    = longint'(cfg_low);
			run_active = 1'b1;
		end
		if (x < run_min) begin
			run_min = x;
		end
		if (x > run_max) begin
			run_max = x;
		end
		if (span > 0 && x >= longint'(cfg_low)) begin
			off = x - longint'(cfg_low);
			bin = (off * k) / span;
			if (bin < k) begin
				if (bin_count[int'(bin)] != COUNT_SAT) begin
					bin_count[int'(bin)]++;
				end
				if (bin_count[int'(bin)] > top_count) begin
					top_count = bin_count[int'(bin)];
				end
			end
		end
		if (!w.final_sample) begin
			return;
		end
		r.kind         = KIND_MIN;
		r.bucket_index = '0;
		r.value        = typed ? want_min : run_min[DATA_W-1:0];
		r.last         = 1'b0;
		report_q.push_back(r);
		r.kind  = KIND_MAX;
		r.value = typed ? want_max : run_max[DATA_W-1:0];
		report_q.push_back(r);
		for (int i = 0; i < k; i++) begin
			share = 0;
			if (top_count != 0) begin
				share = (longint'(bin_count[i]) * SHARE_SCALE2 + longint'(top_count)) /
					(2 * longint'(top_count));
			end
			r.kind         = KIND_SHARE;
			r.bucket_index = i[BKT_W-1:0];
			r.value        = share[DATA_W-1:0];
			r.last         = (i == k - 1);
			report_q.push_back(r);
		end
		clear_histogram();
	endtask

	task automatic pause(input int cycles);
		if (cycles > 0) begin
			start = 1'b0;
			repeat (cycles) @(negedge clk);
		end
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 50) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// Entered and left at a falling edge.
	task automatic send(input logic [DATA_W-1:0] x, input logic fin, input logic typed,
			input logic signed [DATA_W-1:0] want_min,
			input logic signed [DATA_W-1:0] want_max);
		in_t w;
		w.sample       = x;
		w.final_sample = fin;
		start = 1'b1;
		item  = w;
		do @(posedge clk); while (busy);
		histogram_step(w, typed, want_min, want_max);
		items_sent++;
		@(negedge clk);
	endtask

	// The block must be idle: wait out all report words and any sample still in flight.
	task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		start = 1'b0;
		while (report_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_RANGE_LOW:    cfg_low     = data;
			REG_RANGE_HIGH:   cfg_high    = data;
			REG_BUCKET_COUNT: cfg_buckets = data[BKT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic pick_setting();
		int                       r;
		logic signed [DATA_W-1:0] lo;
		logic signed [DATA_W-1:0] hi;
		logic [BKT_W-1:0]         k;
		r = $urandom_range(0, 5);
		case (r)
			0: begin
				lo = 0;
				hi = $urandom_range(0, 5000);
			end
			1: begin
				lo = 32'h8000_0000;
				hi = 32'h7fff_ffff;
			end
			2: begin
				lo = -$urandom_range(0, 100000);
				hi = lo + $urandom_range(0, 200000);
			end
			3: begin
				lo = $urandom;
				hi = $urandom;
			end
			4: begin
				lo = $urandom;
				hi = lo;
			end
			default: begin
				lo = 32'h7fff_ffff - $urandom_range(0, 3000);
				hi = 32'h7fff_ffff;
			end
		endcase
		r = $urandom_range(0, 9);
		case (r)
			0:       k = 0;
			1:       k = 1;
			2:       k = 62;
			3:       k = BUCKETS_MAX;
			default: k = $urandom_range(1, 40);
		endcase
		cfg_write(REG_RANGE_LOW, lo);
		cfg_write(REG_RANGE_HIGH, hi);
		cfg_write(REG_BUCKET_COUNT, {{(DATA_W-BKT_W){1'b0}}, k});
	endtask

	function automatic logic [DATA_W-1:0] draw_sample();
		longint          lo;
		longint          hi;
		longint          span;
		longint unsigned u;
		int              r;
		lo   = longint'(cfg_low);
		hi   = longint'(cfg_high);
		span = hi - lo + 1;
		r    = $urandom_range(0, 9);
		u    = {$urandom, $urandom};
		if (r == 0) begin
			return lo[DATA_W-1:0];
		end else if (r == 1) begin
			return hi[DATA_W-1:0];
		end else if (r < 7 && span > 0) begin
			lo = lo + longint'(u % longint'(span));
			return lo[DATA_W-1:0];
		end else if (r == 7) begin
			return cfg_low - $urandom_range(1, 1000);
		end else if (r == 8) begin
			return cfg_high + $urandom_range(1, 1000);
		end
		return $urandom;
	endfunction

	task automatic plan_cfg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		plan_row_t row;
		row      = '0;
		row.op   = ROW_CFG;
		row.idx  = idx;
		row.data = data;
		plan.push_back(row);
	endtask

	task automatic plan_sample(input logic [DATA_W-1:0] x, input logic fin);
		plan_row_t row;
		row      = '0;
		row.op   = ROW_SAMPLE;
		row.data = x;
		row.fin  = fin;
		plan.push_back(row);
	endtask

	task automatic plan_final(input logic [DATA_W-1:0] x,
			input logic signed [DATA_W-1:0] mn, input logic signed [DATA_W-1:0] mx);
		plan_row_t row;
		row          = '0;
		row.op       = ROW_SAMPLE;
		row.data     = x;
		row.fin      = 1'b1;
		row.typed    = 1'b1;
		row.want_min = mn;
		row.want_max = mx;
		plan.push_back(row);
	endtask

	always @(posedge clk) begin : watch
		out_t want;
		if (arst_n && strobe) begin
			if (report_q.size() == 0) begin
				flag($sformatf("report word with none expected: kind %0d index %0d value %0d",
					result.kind, result.bucket_index, $signed(result.value)));
			end else begin
				want = report_q.pop_front();
				if (result.kind !== want.kind) begin
					flag($sformatf("kind: expected %0d, got %0d", want.kind, result.kind));
				end
				if (result.bucket_index !== want.bucket_index) begin
					flag($sformatf("bucket_index: expected %0d, got %0d",
						want.bucket_index, result.bucket_index));
				end
				if (result.value !== want.value) begin
					flag($sformatf("value (kind %0d, index %0d): expected %0d, got %0d",
						want.kind, want.bucket_index, $signed(want.value),
						$signed(result.value)));
				end
				if (result.last !== want.last) begin
					flag($sformatf("last (index %0d): expected %0b, got %0b",
						want.bucket_index, want.last, result.last));
				end
			end
		end
	end

	initial begin
		int run_len;
		arst_n      = 1'b0;
		start       = 1'b0;
		item        = '0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		fail_count  = 0;
		items_sent  = 0;
		no_idle     = 1'b0;
		cfg_low     = RANGE_LOW_RST;
		cfg_high    = RANGE_HIGH_RST;
		cfg_buckets = BUCKET_COUNT_RST;
		clear_histogram();

		// Reset defaults, then the bounds of the bucket index.
		plan_final(32'd0, 0, 0);
		plan_sample(32'd65535, 1'b0);
		plan_sample(32'hffff_ffff, 1'b0);
		plan_sample(32'd65536, 1'b0);
		plan_final(32'h7fff_ffff, -1, 32'sh7fff_ffff);
		// Full 32-bit span with a bucket count of zero, which acts as one.
		plan_cfg(REG_RANGE_LOW, 32'h8000_0000);
		plan_cfg(REG_RANGE_HIGH, 32'h7fff_ffff);
		plan_cfg(REG_BUCKET_COUNT, 32'd0);
		plan_sample(32'h8000_0000, 1'b0);
		plan_final(32'h7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
		plan_cfg(REG_UNUSED, 32'hffff_ffff);
		// Inverted range with too many buckets: nothing is counted, every share is zero.
		plan_cfg(REG_BUCKET_COUNT, 32'd62);
		plan_cfg(REG_RANGE_LOW, 32'd100);
		plan_cfg(REG_RANGE_HIGH, 32'd50);
		plan_final(32'd75, 50, 100);
		// Empty range.
		plan_cfg(REG_RANGE_LOW, 32'd10);
		plan_cfg(REG_RANGE_HIGH, 32'd9);
		plan_final(32'd9, 9, 10);
		// The upper bound moves in the middle of a run.
		plan_cfg(REG_RANGE_LOW, 32'd0);
		plan_cfg(REG_RANGE_HIGH, 32'd999);
		plan_cfg(REG_BUCKET_COUNT, 32'd10);
		plan_sample(32'd5, 1'b0);
		plan_sample(32'd500, 1'b0);
		plan_sample(32'd999, 1'b0);
		plan_cfg(REG_RANGE_HIGH, 32'd99);
		plan_sample(32'd50, 1'b0);
		plan_sample(32'd150, 1'b1);
		plan_cfg(REG_RANGE_HIGH, 32'd3);
		plan_cfg(REG_BUCKET_COUNT, 32'd1);
		plan_sample(32'd3, 1'b0);
		plan_sample(32'd3, 1'b0);
		plan_sample(32'd2, 1'b0);
		plan_sample(32'd0, 1'b1);
		plan_cfg(REG_RANGE_LOW, -32'sd1000);
		plan_cfg(REG_RANGE_HIGH, 32'd1000);
		plan_cfg(REG_BUCKET_COUNT, 32'd31);
		plan_sample(-32'sd1000, 1'b0);
		plan_sample(32'd0, 1'b0);
		plan_sample(32'd1000, 1'b0);
		plan_sample(32'd1001, 1'b1);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].op == ROW_CFG) begin
				cfg_write(plan[i].idx, plan[i].data);
			end else begin
				pause(gap_len());
				send(plan[i].data, plan[i].fin, plan[i].typed, plan[i].want_min,
					plan[i].want_max);
			end
		end

		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 2) == 0) begin
				pick_setting();
			end
			no_idle = ($urandom_range(0, 3) == 0);
			run_len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 12);
			for (int n = 0; n < run_len; n++) begin
				if (n != 0 && $urandom_range(0, 19) == 0) begin
					pick_setting();
				end
				pause(gap_len());
				send(draw_sample(), n == run_len - 1, 1'b0, '0, '0);
			end
		end
		start = 1'b0;

		while (report_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0 && report_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
